FILE: design/jltc_pkg.sv
`default_nettype none

package jltc_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_LEFT_MUL,
        ST_LEFT_ACC,
        ST_RIGHT_MUL,
        ST_RIGHT_ACC,
        ST_PULL_L_MUL,
        ST_PULL_L_ACC,
        ST_PULL_R_MUL,
        ST_PULL_R_ACC,
        ST_DIV_WAIT,
        ST_SUM
    } state_t;

    // Which offset update the shared multiplier and accumulator work on
    typedef enum logic [1:0] {
        STEP_LEFT,
        STEP_RIGHT,
        STEP_PULL_L,
        STEP_PULL_R
    } step_t;

    typedef struct packed {
        logic  capture;
        logic  div_start;
        logic  mul_en;
        logic  acc_en;
        step_t step;
        logic  load_out;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic request;
        logic out_free;
    } status_t;

    localparam logic [2:0] CFG_ROLL_DIVISOR     = 3'd0;
    localparam logic [2:0] CFG_PITCH_DIVISOR    = 3'd1;
    localparam logic [2:0] CFG_LIMIT_GAIN       = 3'd2;
    localparam logic [2:0] CFG_LEFT_HIP_MAX     = 3'd3;
    localparam logic [2:0] CFG_LEFT_ANKLE_MIN   = 3'd4;
    localparam logic [2:0] CFG_RIGHT_HIP_MAX    = 3'd5;
    localparam logic [2:0] CFG_RIGHT_ANKLE_MIN  = 3'd6;

    // 0.05 in Q0.16
    localparam logic [15:0] BONUS_GAIN   = 16'd3277;
    localparam logic [15:0] DIVISOR_RST  = 16'd256;
    localparam int          DIV_STEPS    = 24;
    localparam int          DIV_CNT_W    = $clog2(DIV_STEPS + 1);

endpackage

`default_nettype wire

FILE: design/jltc_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle
module jltc_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [23:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic [23:0]      quotient
);

    logic [jltc_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [jltc_pkg::DIV_CNT_W-1:0] cnt_next;
    logic [23:0] quo_reg;
    logic [23:0] quo_next;
    logic [15:0] rem_reg;
    logic [15:0] rem_next;
    logic [15:0] div_reg;
    logic [16:0] trial;
    logic [16:0] diff;

    assign trial = {rem_reg, quo_reg[23]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (start)
        begin
            cnt_next = jltc_pkg::DIV_CNT_W'(jltc_pkg::DIV_STEPS);
            quo_next = dividend;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - jltc_pkg::DIV_CNT_W'(1);
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[15:0];
                quo_next = {quo_reg[22:0], 1'b1};
            end
            else
            begin
                rem_next = trial[15:0];
                quo_next = {quo_reg[22:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
            div_reg <= (divisor == '0) ? 16'd1 : divisor;
    end

    assign done     = (cnt_reg == '0);
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: design/jltc_datapath.sv
`default_nettype none

module jltc_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [15:0]       cfg_wdata,
    input  wire logic [95:0]       s_tdata,
    input  wire logic              s_tuser,
    input  wire jltc_pkg::cmd_t    cmd,
    output jltc_pkg::status_t      status,
    output logic [31:0]            m_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready
);

    function automatic logic [23:0] sat24(input logic signed [24:0] v);
        if (v > 25'sd8388607)
            return 24'h7FFFFF;
        else if (v < -25'sd8388608)
            return 24'h800000;
        else
            return v[23:0];
    endfunction

    function automatic logic [15:0] sat16(input logic signed [26:0] v);
        if (v > 27'sd32767)
            return 16'h7FFF;
        else if (v < -27'sd32768)
            return 16'h8000;
        else
            return v[15:0];
    endfunction

    // Excess of a over b, zero when a <= b
    function automatic logic [15:0] excess(input logic [15:0] a, input logic [15:0] b);
        logic signed [16:0] d;
        d = $signed({a[15], a}) - $signed({b[15], b});
        return (d > 17'sd0) ? d[15:0] : 16'd0;
    endfunction

    function automatic logic [15:0] umax(input logic [15:0] a, input logic [15:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [15:0] umin(input logic [15:0] a, input logic [15:0] b);
        return (a < b) ? a : b;
    endfunction

    logic [15:0] roll_div_reg;
    logic [15:0] pitch_div_reg;
    logic [15:0] gain_reg;
    logic [15:0] lh_max_reg;
    logic [15:0] la_min_reg;
    logic [15:0] rh_max_reg;
    logic [15:0] ra_min_reg;

    logic [15:0] roll_reg;
    logic [15:0] pitch_reg;
    logic        req_reg;
    logic [15:0] lh_reg;
    logic [15:0] la_reg;
    logic [15:0] rh_reg;
    logic [15:0] ra_reg;

    logic [23:0] offset_reg;
    logic [23:0] offset_next;
    logic [31:0] mul_reg;
    logic [31:0] m_tdata_reg;
    logic        m_tvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_div_reg  <= jltc_pkg::DIVISOR_RST;
            pitch_div_reg <= jltc_pkg::DIVISOR_RST;
            gain_reg      <= '0;
            lh_max_reg    <= '0;
            la_min_reg    <= '0;
            rh_max_reg    <= '0;
            ra_min_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                jltc_pkg::CFG_ROLL_DIVISOR:    roll_div_reg  <= cfg_wdata;
                jltc_pkg::CFG_PITCH_DIVISOR:   pitch_div_reg <= cfg_wdata;
                jltc_pkg::CFG_LIMIT_GAIN:      gain_reg      <= cfg_wdata;
                jltc_pkg::CFG_LEFT_HIP_MAX:    lh_max_reg    <= cfg_wdata;
                jltc_pkg::CFG_LEFT_ANKLE_MIN:  la_min_reg    <= cfg_wdata;
                jltc_pkg::CFG_RIGHT_HIP_MAX:   rh_max_reg    <= cfg_wdata;
                jltc_pkg::CFG_RIGHT_ANKLE_MIN: ra_min_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            roll_reg  <= s_tdata[15:0];
            pitch_reg <= s_tdata[31:16];
            lh_reg    <= s_tdata[47:32];
            la_reg    <= s_tdata[63:48];
            rh_reg    <= s_tdata[79:64];
            ra_reg    <= s_tdata[95:80];
            req_reg   <= s_tuser;
        end
    end

    // Attenuation: |angle| * 256 / divisor, sign restored afterwards
    logic        roll_neg;
    logic        pitch_neg;
    logic [15:0] roll_abs;
    logic [15:0] pitch_abs;
    logic [23:0] roll_quo;
    logic [23:0] pitch_quo;
    logic        roll_done;
    logic        pitch_done;

    assign roll_neg  = roll_reg[15];
    assign pitch_neg = pitch_reg[15];
    assign roll_abs  = roll_neg ? (16'd0 - roll_reg) : roll_reg;
    assign pitch_abs = pitch_neg ? (16'd0 - pitch_reg) : pitch_reg;

    jltc_div u_roll_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({roll_abs, 8'd0}),
        .divisor  (roll_div_reg),
        .done     (roll_done),
        .quotient (roll_quo)
    );

    jltc_div u_pitch_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({pitch_abs, 8'd0}),
        .divisor  (pitch_div_reg),
        .done     (pitch_done),
        .quotient (pitch_quo)
    );

    logic signed [24:0] roll_q;
    logic signed [24:0] pitch_q;
    logic signed [25:0] roll_att;
    logic signed [25:0] pitch_att;
    logic signed [26:0] roll_sum;

    assign roll_q    = roll_neg ? -$signed({1'b0, roll_quo}) : $signed({1'b0, roll_quo});
    assign pitch_q   = pitch_neg ? -$signed({1'b0, pitch_quo}) : $signed({1'b0, pitch_quo});
    assign roll_att  = 26'($signed(roll_reg)) - 26'(roll_q);
    assign pitch_att = 26'($signed(pitch_reg)) - 26'(pitch_q);
    assign roll_sum  = 27'(roll_att) + 27'($signed(offset_reg));

    // Overshoot and pull-back distances
    logic [15:0] ov_left;
    logic [15:0] ov_right;
    logic [15:0] dist_left;
    logic [15:0] dist_right;
    logic        inside_left;
    logic        inside_right;
    logic [15:0] pull_gain;

    assign ov_left  = umax(excess(lh_reg, lh_max_reg), excess(la_min_reg, la_reg));
    assign ov_right = umax(excess(rh_reg, rh_max_reg), excess(ra_min_reg, ra_reg));
    assign inside_left  = ($signed(la_reg) > $signed(la_min_reg)) &&
                          ($signed(lh_reg) < $signed(lh_max_reg));
    assign inside_right = ($signed(ra_reg) > $signed(ra_min_reg)) &&
                          ($signed(rh_reg) < $signed(rh_max_reg));
    assign dist_left  = umin(excess(lh_max_reg, lh_reg), excess(la_reg, la_min_reg));
    assign dist_right = umin(excess(rh_max_reg, rh_reg), excess(ra_reg, ra_min_reg));
    assign pull_gain  = (gain_reg == '0) ? jltc_pkg::BONUS_GAIN : gain_reg;

    logic [15:0] gain_sel;
    logic [15:0] amt_sel;

    always_comb
    begin
        unique case (cmd.step)
            jltc_pkg::STEP_LEFT:
            begin
                gain_sel = gain_reg;
                amt_sel  = ov_left;
            end
            jltc_pkg::STEP_RIGHT:
            begin
                gain_sel = gain_reg;
                amt_sel  = ov_right;
            end
            jltc_pkg::STEP_PULL_L:
            begin
                gain_sel = pull_gain;
                amt_sel  = dist_left;
            end
            jltc_pkg::STEP_PULL_R:
            begin
                gain_sel = pull_gain;
                amt_sel  = dist_right;
            end
            default:
            begin
                gain_sel = gain_reg;
                amt_sel  = ov_left;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            mul_reg <= gain_sel * amt_sel;
    end

    logic [15:0]        scaled;
    logic signed [24:0] ofs_ext;
    logic signed [24:0] ofs_neg;
    logic signed [24:0] dist_ext;

    assign scaled  = mul_reg[31:16];
    assign ofs_ext = 25'($signed(offset_reg));
    assign ofs_neg = -ofs_ext;

    always_comb
    begin
        offset_next = offset_reg;
        dist_ext    = '0;
        unique case (cmd.step)
            jltc_pkg::STEP_LEFT:
                offset_next = sat24(ofs_ext - $signed({9'd0, scaled}));
            jltc_pkg::STEP_RIGHT:
                offset_next = sat24(ofs_ext + $signed({9'd0, scaled}));
            jltc_pkg::STEP_PULL_L:
            begin
                dist_ext = $signed({9'd0, dist_left});
                if (inside_left && offset_reg[23])
                begin
                    if (dist_ext > ofs_neg)
                        offset_next = '0;
                    else
                        offset_next = offset_reg + {8'd0, scaled};
                end
            end
            jltc_pkg::STEP_PULL_R:
            begin
                dist_ext = $signed({9'd0, dist_right});
                if (inside_right && !offset_reg[23] && offset_reg != '0)
                begin
                    if (dist_ext > ofs_ext)
                        offset_next = '0;
                    else
                        offset_next = offset_reg - {8'd0, scaled};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            offset_reg <= '0;
        else if (cmd.acc_en)
            offset_reg <= offset_next;
    end

    // Output register: hold until the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.load_out)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
            m_tdata_reg <= {sat16(27'(pitch_att)), sat16(roll_sum)};
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

    assign status.div_done = roll_done & pitch_done;
    assign status.request  = req_reg;
    assign status.out_free = !m_tvalid_reg || m_tready;

endmodule

`default_nettype wire

FILE: design/jltc_ctrl.sv
`default_nettype none

module jltc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire jltc_pkg::status_t status,
    output jltc_pkg::cmd_t         cmd
);

    jltc_pkg::state_t state_reg;
    jltc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= jltc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            jltc_pkg::ST_IDLE:
                if (s_tvalid)
                    state_next = jltc_pkg::ST_DIV_START;
            jltc_pkg::ST_DIV_START:
                state_next = status.request ? jltc_pkg::ST_LEFT_MUL : jltc_pkg::ST_DIV_WAIT;
            jltc_pkg::ST_LEFT_MUL:    state_next = jltc_pkg::ST_LEFT_ACC;
            jltc_pkg::ST_LEFT_ACC:    state_next = jltc_pkg::ST_RIGHT_MUL;
            jltc_pkg::ST_RIGHT_MUL:   state_next = jltc_pkg::ST_RIGHT_ACC;
            jltc_pkg::ST_RIGHT_ACC:   state_next = jltc_pkg::ST_PULL_L_MUL;
            jltc_pkg::ST_PULL_L_MUL:  state_next = jltc_pkg::ST_PULL_L_ACC;
            jltc_pkg::ST_PULL_L_ACC:  state_next = jltc_pkg::ST_PULL_R_MUL;
            jltc_pkg::ST_PULL_R_MUL:  state_next = jltc_pkg::ST_PULL_R_ACC;
            jltc_pkg::ST_PULL_R_ACC:  state_next = jltc_pkg::ST_DIV_WAIT;
            jltc_pkg::ST_DIV_WAIT:
                if (status.div_done)
                    state_next = jltc_pkg::ST_SUM;
            jltc_pkg::ST_SUM:
                if (status.out_free)
                    state_next = jltc_pkg::ST_IDLE;
            default:
                state_next = jltc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.step  = jltc_pkg::STEP_LEFT;
        s_tready  = 1'b0;
        unique case (state_reg)
            jltc_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            jltc_pkg::ST_DIV_START:
                cmd.div_start = 1'b1;
            jltc_pkg::ST_LEFT_MUL:
                cmd.mul_en = 1'b1;
            jltc_pkg::ST_LEFT_ACC:
                cmd.acc_en = 1'b1;
            jltc_pkg::ST_RIGHT_MUL:
            begin
                cmd.mul_en = 1'b1;
                cmd.step   = jltc_pkg::STEP_RIGHT;
            end
            jltc_pkg::ST_RIGHT_ACC:
            begin
                cmd.acc_en = 1'b1;
                cmd.step   = jltc_pkg::STEP_RIGHT;
            end
            jltc_pkg::ST_PULL_L_MUL:
            begin
                cmd.mul_en = 1'b1;
                cmd.step   = jltc_pkg::STEP_PULL_L;
            end
            jltc_pkg::ST_PULL_L_ACC:
            begin
                cmd.acc_en = 1'b1;
                cmd.step   = jltc_pkg::STEP_PULL_L;
            end
            jltc_pkg::ST_PULL_R_MUL:
            begin
                cmd.mul_en = 1'b1;
                cmd.step   = jltc_pkg::STEP_PULL_R;
            end
            jltc_pkg::ST_PULL_R_ACC:
            begin
                cmd.acc_en = 1'b1;
                cmd.step   = jltc_pkg::STEP_PULL_R;
            end
            jltc_pkg::ST_DIV_WAIT: ;
            jltc_pkg::ST_SUM:
                cmd.load_out = status.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

FILE: design/joint_limit_tilt_controller.sv
// An input transfer leads to a result on m_tvalid once the output is free; a new input
// is taken only after that result is loaded. The 24-step restoring dividers for the
// roll and pitch attenuation set the pace, the offset update runs alongside them.
// A result held in the output register does not block the next input transfer.
// Reset (rst_n low, asynchronous): divisors to 256, gain and limits to zero,
// roll offset to zero, no result pending.
`default_nettype none

module joint_limit_tilt_controller (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // body_roll, body_pitch, left_hip_roll, left_ankle_roll,
    // right_hip_roll, right_ankle_roll
    input  wire logic [95:0] s_tdata,
    // request_present
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tilt_roll, tilt_pitch
    output logic [31:0]      m_tdata
);

    jltc_pkg::cmd_t    cmd;
    jltc_pkg::status_t status;

    jltc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    jltc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready)
    );

endmodule

`default_nettype wire

FILE: design/jltc_checker.sv
`default_nettype none

module jltc_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [95:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata
);

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Block stays busy for the cycles after an input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("input taken again during computation");

    // A new result appears only at the end of a computation
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without computation");

    // No result appears right after an input is accepted while no result was pending
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result produced too early");

endmodule

bind joint_limit_tilt_controller jltc_checker u_jltc_checker (.*);

`default_nettype wire
